>>> rtl/stmd_pkg.sv
`default_nettype none

package stmd_pkg;

  localparam int unsigned ACC_W         = 64;
  localparam int unsigned TARGET_W      = 16;
  localparam int unsigned MAG_W         = TARGET_W + 1;
  localparam int unsigned SPEED_W       = 11;
  localparam int unsigned DUTY_W        = 8;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 11;
  localparam int unsigned NUM_COEF      = 7;
  localparam int unsigned COEF_SRC_FRAC = 56;
  // magnitude is scaled by 1/16 inside each multiply
  localparam int unsigned SPEED_SHIFT   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY  = CFG_IDX_W'(3);

  localparam logic [SPEED_W-1:0] MIN_SPEED_RST = SPEED_W'(9);
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = SPEED_W'(150);
  localparam logic [DUTY_W-1:0]  MIN_DUTY_RST  = DUTY_W'(22);
  localparam logic [DUTY_W-1:0]  MAX_DUTY_RST  = DUTY_W'(255);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // c0 .. c6 with 56 fraction bits
  localparam logic signed [ACC_W-1:0] COEF56 [NUM_COEF] = '{
    -64'sd1283716990539979945,
    64'sd391986610210082445,
    -64'sd16359796029611811,
    64'sd367248589658515,
    -64'sd4139050891645,
    64'sd22794778561,
    -64'sd48026386
  };

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             below;
    logic             above;
    logic             zero_cmd;
  } lane_t;

  typedef struct packed {
    logic              drive_a;
    logic              drive_b;
    logic [DUTY_W-1:0] duty;
    logic              out_of_range;
  } result_t;

  // coefficient k rounded half away from zero to frac fraction bits
  function automatic logic signed [ACC_W-1:0] coef_at(int unsigned k, int unsigned frac);
    logic signed [ACC_W-1:0] c;
    logic [ACC_W-1:0]        mag;
    int unsigned             s;
    c = COEF56[k];
    s = COEF_SRC_FRAC - frac;
    if (s == 0) begin
      return c;
    end
    mag = c[ACC_W-1] ? ('0 - $unsigned(c)) : $unsigned(c);
    mag = (mag + (ACC_W'(1) << (s - 1))) >> s;
    return c[ACC_W-1] ? $signed('0 - mag) : $signed(mag);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sum(logic signed [ACC_W:0] x);
    if (x[ACC_W] != x[ACC_W-1]) begin
      return x[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return x[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/stmd_if.sv
`default_nettype none

interface stmd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [stmd_pkg::TARGET_W-1:0]    target_speed;

  modport source (output valid, output target_speed, input ready);
  modport sink   (input valid, input target_speed, output ready);
endinterface

interface stmd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          drive_a;
  logic                          drive_b;
  logic [stmd_pkg::DUTY_W-1:0]   duty;
  logic                          out_of_range;

  modport source (output valid, output drive_a, output drive_b, output duty,
                  output out_of_range, input ready);
  modport sink   (input valid, input drive_a, input drive_b, input duty,
                  input out_of_range, output ready);
endinterface

interface stmd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [stmd_pkg::CFG_IDX_W-1:0]    index;
  logic [stmd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/stmd_front.sv
`default_nettype none

module stmd_front #(
  parameter int unsigned COEF_FRAC_BITS = 48
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire logic signed [stmd_pkg::TARGET_W-1:0]  target_i,
  input  wire logic [stmd_pkg::SPEED_W-1:0]          min_speed_i,
  input  wire logic [stmd_pkg::SPEED_W-1:0]          max_speed_i,
  output logic                                       valid_o,
  output logic signed [stmd_pkg::ACC_W-1:0]          acc_o,
  output stmd_pkg::lane_t                            lane_o
);

  localparam int unsigned MAG_W = stmd_pkg::MAG_W;
  localparam int unsigned PAD_W = MAG_W - stmd_pkg::SPEED_W - stmd_pkg::SPEED_SHIFT;

  logic             valid_q;
  stmd_pkg::lane_t  lane_d, lane_q;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] lo_bound;
  logic [MAG_W-1:0] hi_bound;
  logic [MAG_W-1:0] raw_ext;

  assign raw_ext  = {1'b0, $unsigned(target_i)};
  // two's complement magnitude, -32768 gives 32768
  assign mag      = target_i[stmd_pkg::TARGET_W-1] ? ((MAG_W'(1) << stmd_pkg::TARGET_W) - raw_ext)
                                                   : raw_ext;
  assign lo_bound = {{PAD_W{1'b0}}, min_speed_i, {stmd_pkg::SPEED_SHIFT{1'b0}}};
  assign hi_bound = {{PAD_W{1'b0}}, max_speed_i, {stmd_pkg::SPEED_SHIFT{1'b0}}};

  always_comb begin
    lane_d.mag      = mag;
    lane_d.neg      = target_i[stmd_pkg::TARGET_W-1];
    lane_d.below    = mag < lo_bound;
    lane_d.above    = mag > hi_bound;
    lane_d.zero_cmd = mag == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  // horner starts from the leading coefficient
  assign acc_o   = stmd_pkg::coef_at(stmd_pkg::NUM_COEF - 1, COEF_FRAC_BITS);

endmodule

`default_nettype wire

>>> rtl/stmd_horner.sv
`default_nettype none

// one horner step: acc' = sat(sat(sat(q*m) + rem*m/16) + c_k), three stages
module stmd_horner #(
  parameter int unsigned COEF_FRAC_BITS = 48,
  parameter int unsigned K              = 0
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic signed [stmd_pkg::ACC_W-1:0] acc_i,
  input  wire stmd_pkg::lane_t                   lane_i,
  output logic                                   valid_o,
  output logic signed [stmd_pkg::ACC_W-1:0]      acc_o,
  output stmd_pkg::lane_t                        lane_o
);

  localparam int unsigned ACC_W  = stmd_pkg::ACC_W;
  localparam int unsigned MAG_W  = stmd_pkg::MAG_W;
  localparam int unsigned SH     = stmd_pkg::SPEED_SHIFT;
  localparam int unsigned Q_W    = ACC_W - SH;
  localparam int unsigned QLO_W  = Q_W / 2;
  localparam int unsigned QHI_W  = Q_W - QLO_W;
  localparam int unsigned PLO_W  = QLO_W + MAG_W;
  localparam int unsigned PHI_W  = QHI_W + MAG_W + 1;
  localparam int unsigned FULL_W = PHI_W + QLO_W + 1;
  localparam int unsigned REM_W  = SH + MAG_W;
  localparam logic signed [ACC_W-1:0] COEF = stmd_pkg::coef_at(K, COEF_FRAC_BITS);

  // stage a: split partial products
  logic                     valid_a_q;
  stmd_pkg::lane_t          lane_a_q;
  logic [PLO_W-1:0]         plo_d, plo_q;
  logic signed [PHI_W-1:0]  phi_d, phi_q;
  logic [MAG_W-1:0]         frac_d, frac_q;
  logic [QLO_W-1:0]         q_lo;
  logic signed [QHI_W-1:0]  q_hi;
  logic signed [MAG_W:0]    mag_s;
  logic [REM_W-1:0]         rem_prod;

  // floor(acc/16) is the arithmetic shift, remainder the low nibble
  assign q_lo     = acc_i[SH +: QLO_W];
  assign q_hi     = acc_i[ACC_W-1 -: QHI_W];
  assign mag_s    = $signed({1'b0, lane_i.mag});
  assign plo_d    = PLO_W'(q_lo) * PLO_W'(lane_i.mag);
  assign phi_d    = q_hi * mag_s;
  assign rem_prod = REM_W'(acc_i[SH-1:0]) * REM_W'(lane_i.mag);
  assign frac_d   = rem_prod[REM_W-1:SH];

  // stage b: rebuild product, saturate, add remainder part
  logic                     valid_b_q;
  stmd_pkg::lane_t          lane_b_q;
  logic signed [FULL_W-1:0] hi_ext, lo_ext, full;
  logic [FULL_W-ACC_W:0]    top_bits;
  logic signed [ACC_W-1:0]  prod_sat;
  logic signed [ACC_W-1:0]  sum_d, sum_q;

  assign hi_ext   = {{(FULL_W-PHI_W){phi_q[PHI_W-1]}}, phi_q};
  assign lo_ext   = $signed({{(FULL_W-PLO_W){1'b0}}, plo_q});
  assign full     = (hi_ext <<< QLO_W) + lo_ext;
  assign top_bits = full[FULL_W-1:ACC_W-1];
  assign prod_sat = ((&top_bits) || !(|top_bits)) ? full[ACC_W-1:0]
                  : (full[FULL_W-1] ? stmd_pkg::ACC_MIN : stmd_pkg::ACC_MAX);
  assign sum_d    = stmd_pkg::sat_sum({prod_sat[ACC_W-1], prod_sat}
                                      + $signed({{(ACC_W+1-MAG_W){1'b0}}, frac_q}));

  // stage c: add coefficient
  logic                     valid_c_q;
  stmd_pkg::lane_t          lane_c_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;

  assign acc_d = stmd_pkg::sat_sum({sum_q[ACC_W-1], sum_q} + {COEF[ACC_W-1], COEF});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_a_q <= lane_i;
      plo_q    <= plo_d;
      phi_q    <= phi_d;
      frac_q   <= frac_d;
      lane_b_q <= lane_a_q;
      sum_q    <= sum_d;
      lane_c_q <= lane_b_q;
      acc_q    <= acc_d;
    end
  end

  assign valid_o = valid_c_q;
  assign acc_o   = acc_q;
  assign lane_o  = lane_c_q;

endmodule

`default_nettype wire

>>> rtl/stmd_out.sv
`default_nettype none

// duty scaling and clamp, then output register with one skid entry
module stmd_out #(
  parameter int unsigned COEF_FRAC_BITS = 48
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic signed [stmd_pkg::ACC_W-1:0] acc_i,
  input  wire stmd_pkg::lane_t                   lane_i,
  input  wire logic [stmd_pkg::DUTY_W-1:0]       min_duty_i,
  input  wire logic [stmd_pkg::DUTY_W-1:0]       max_duty_i,
  output logic                                   en_o,
  stmd_out_if.source                             out_o
);

  localparam int unsigned ACC_W  = stmd_pkg::ACC_W;
  localparam int unsigned DUTY_W = stmd_pkg::DUTY_W;
  localparam int unsigned RAW_W  = ACC_W - COEF_FRAC_BITS;

  logic [ACC_W-1:0]  acc_mag;
  logic [RAW_W-1:0]  raw;
  logic              raw_neg;
  logic [DUTY_W-1:0] poly_duty;
  logic              off;
  stmd_pkg::result_t res_d, out_q, skid_q;

  // truncate toward zero: shift the magnitude
  assign acc_mag = acc_i[ACC_W-1] ? ('0 - $unsigned(acc_i)) : $unsigned(acc_i);
  assign raw     = acc_mag[ACC_W-1:COEF_FRAC_BITS];
  assign raw_neg = acc_i[ACC_W-1] && (raw != '0);

  always_comb begin
    if (raw_neg || (raw < RAW_W'(min_duty_i))) begin
      poly_duty = min_duty_i;
    end else if (raw > RAW_W'(max_duty_i)) begin
      poly_duty = max_duty_i;
    end else begin
      poly_duty = raw[DUTY_W-1:0];
    end
  end

  assign off = lane_i.below || lane_i.above || lane_i.zero_cmd;

  always_comb begin
    res_d.drive_a      = !off && !lane_i.neg;
    res_d.drive_b      = !off && lane_i.neg;
    res_d.out_of_range = off;
    if (lane_i.below) begin
      res_d.duty = min_duty_i;
    end else if (lane_i.above) begin
      res_d.duty = max_duty_i;
    end else begin
      res_d.duty = poly_duty;
    end
  end

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  logic pop, push, load_out, load_skid, out_from_skid;

  assign en_o = !skid_valid_q;
  assign pop  = out_valid_q && out_o.ready;
  assign push = valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        load_out      = 1'b1;
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_skid) begin
      skid_q <= res_d;
    end
    if (load_out) begin
      out_q <= out_from_skid ? skid_q : res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_a      = out_q.drive_a;
  assign out_o.drive_b      = out_q.drive_b;
  assign out_o.duty         = out_q.duty;
  assign out_o.out_of_range = out_q.out_of_range;

endmodule

`default_nettype wire

>>> rtl/speed_to_motor_drive_map_core.sv
// channel  | dir | payload                                      | role
// ---------+-----+----------------------------------------------+---------------------------
// in_i     | in  | target_speed (s16, 1/16 rpm)                 | speed command
// out_o    | out | drive_a, drive_b, duty (u8), out_of_range    | bridge drive per command
// cfg_i    | in  | index (u8), data (u11)                       | register writes, always ready
//
// one command per cycle while in_i.ready is high; from in transfer to out valid the pipe holds:
// window decode 1, six horner steps of 3 stages each (split 30x17 multiply, saturate, add), 1 out
// reset clears all valid bits and loads the register defaults 9, 150, 22, 255
// the whole pipe advances together; out register plus one skid entry keep in_i.ready high
// while one result waits, in_i.ready drops the cycle after the skid entry fills
`default_nettype none

module speed_to_motor_drive_map_core #(
  parameter int unsigned COEF_FRAC_BITS = 48
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stmd_in_if.sink     in_i,
  stmd_out_if.source  out_o,
  stmd_cfg_if.sink    cfg_i
);

  localparam int unsigned NUM_STEPS = stmd_pkg::NUM_COEF - 1;

  logic [stmd_pkg::SPEED_W-1:0] min_speed_q, max_speed_q;
  logic [stmd_pkg::DUTY_W-1:0]  min_duty_q, max_duty_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q <= stmd_pkg::MIN_SPEED_RST;
      max_speed_q <= stmd_pkg::MAX_SPEED_RST;
      min_duty_q  <= stmd_pkg::MIN_DUTY_RST;
      max_duty_q  <= stmd_pkg::MAX_DUTY_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        stmd_pkg::REG_MIN_SPEED: min_speed_q <= cfg_i.data[stmd_pkg::SPEED_W-1:0];
        stmd_pkg::REG_MAX_SPEED: max_speed_q <= cfg_i.data[stmd_pkg::SPEED_W-1:0];
        stmd_pkg::REG_MIN_DUTY:  min_duty_q  <= cfg_i.data[stmd_pkg::DUTY_W-1:0];
        stmd_pkg::REG_MAX_DUTY:  max_duty_q  <= cfg_i.data[stmd_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic                               en;
  logic                               st_valid [NUM_STEPS+1];
  logic signed [stmd_pkg::ACC_W-1:0]  st_acc   [NUM_STEPS+1];
  stmd_pkg::lane_t                    st_lane  [NUM_STEPS+1];

  assign in_i.ready = en;

  stmd_front #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .target_i    (in_i.target_speed),
    .min_speed_i (min_speed_q),
    .max_speed_i (max_speed_q),
    .valid_o     (st_valid[0]),
    .acc_o       (st_acc[0]),
    .lane_o      (st_lane[0])
  );

  for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
    stmd_horner #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .K             (NUM_STEPS - 1 - j)
    ) u_horner (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_valid[j]),
      .acc_i   (st_acc[j]),
      .lane_i  (st_lane[j]),
      .valid_o (st_valid[j+1]),
      .acc_o   (st_acc[j+1]),
      .lane_o  (st_lane[j+1])
    );
  end

  stmd_out #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (st_valid[NUM_STEPS]),
    .acc_i      (st_acc[NUM_STEPS]),
    .lane_i     (st_lane[NUM_STEPS]),
    .min_duty_i (min_duty_q),
    .max_duty_i (max_duty_q),
    .en_o       (en),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/stmd_chk.sv
`default_nettype none

module stmd_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        drive_a_i,
  input wire logic                        drive_b_i,
  input wire logic [stmd_pkg::DUTY_W-1:0] duty_i,
  input wire logic                        out_of_range_i
);

  // the bridge is never driven both ways
  a_no_shoot_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(drive_a_i && drive_b_i))
    else $error("both bridge lines high");

  // exactly one line is driven when in range, none when out of range
  a_flag_vs_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_of_range_i != (drive_a_i || drive_b_i)))
    else $error("out_of_range disagrees with drive lines");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable({drive_a_i, drive_b_i, duty_i, out_of_range_i})))
    else $error("stalled result changed");

  // input backpressure only follows a stalled result
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(out_valid_i && !out_ready_i))
    else $error("in ready dropped without output stall");

endmodule

bind speed_to_motor_drive_map_core stmd_chk u_stmd_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .drive_a_i      (out_o.drive_a),
  .drive_b_i      (out_o.drive_b),
  .duty_i         (out_o.duty),
  .out_of_range_i (out_o.out_of_range)
);

`default_nettype wire

>>> dv/speed_to_motor_drive_map_core_tb.sv
`timescale 1ns / 100ps

module speed_to_motor_drive_map_core_tb;

  localparam int     FRAC        = 48;
  localparam int     NUM_PHASES  = 12;
  localparam int     RAND_PER_PH = 74;
  localparam int     CYCLE_LIMIT = 600000;
  localparam longint I64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN     = -I64_MAX - 64'sd1;

  // c0 .. c6, 56 fraction bits
  localparam longint DUTY_COEF_Q56 [7] = '{
    -64'sd1283716990539979945,
    64'sd391986610210082445,
    -64'sd16359796029611811,
    64'sd367248589658515,
    -64'sd4139050891645,
    64'sd22794778561,
    -64'sd48026386
  };

  // min_speed, max_speed, min_duty, max_duty
  localparam int SETTING_TBL [8][4] = '{
    '{0, 2047, 0, 255},
    '{2047, 0, 255, 0},
    '{0, 0, 0, 0},
    '{2047, 2047, 255, 255},
    '{9, 150, 22, 255},
    '{20, 120, 40, 200},
    '{5, 200, 200, 100},
    '{1, 2047, 30, 180}
  };

  logic clk;
  logic rst_n;

  stmd_in_if  in_ch ();
  stmd_out_if out_ch ();
  stmd_cfg_if cfg_ch ();

  speed_to_motor_drive_map_core #(
    .COEF_FRAC_BITS(FRAC)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // register copies seen by the duty predictor
  int lo_rpm  = 9;
  int hi_rpm  = 150;
  int lo_duty = 22;
  int hi_duty = 255;

  logic signed [15:0] cmd_q [$];
  stmd_pkg::result_t  drive_exp_q [$];

  int                popped_cnt = 0;
  int                checked_cnt = 0;
  int                err_cnt = 0;
  int                cycle_cnt = 0;
  int                src_gap;
  int                snk_stall;
  bit                src_idle_en = 1'b1;
  bit                snk_stall_en = 1'b1;
  stmd_pkg::result_t want_r;
  stmd_pkg::result_t got_r;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  function automatic longint sat64(logic signed [127:0] w);
    if (w > 128'(I64_MAX)) return I64_MAX;
    if (w < 128'(I64_MIN)) return I64_MIN;
    return w[63:0];
  endfunction

  // coefficient rounded half away from zero to FRAC fraction bits
  function automatic longint horner_coef(int k);
    longint      c;
    logic [63:0] mag;
    int          s;
    c = DUTY_COEF_Q56[k];
    s = 56 - FRAC;
    if (s == 0) return c;
    mag = (c < 0) ? -c : c;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (c < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // raw duty from the polynomial, m in 1/16 rpm
  function automatic longint duty_poly(int m);
    longint             acc;
    longint             q;
    int                 rem;
    int                 k;
    logic signed [127:0] w;
    acc = horner_coef(6);
    for (k = 5; k >= 0; k--) begin
      q   = acc >>> 4;
      rem = int'(acc & 64'sd15);
      acc = sat64(128'(q) * 128'(m));
      acc = sat64(128'(acc) + 128'((rem * m) / 16));
      acc = sat64(128'(acc) + 128'(horner_coef(k)));
    end
    w = 128'(acc);
    if (w < 0) w = -((-w) >>> FRAC);
    else w = w >>> FRAC;
    return w[63:0];
  endfunction

  function automatic stmd_pkg::result_t drive_for_speed(logic signed [15:0] tgt);
    int                m;
    bit                neg;
    bit                below;
    bit                above;
    bit                off;
    longint            p;
    stmd_pkg::result_t r;
    neg   = tgt[15];
    m     = neg ? -int'(tgt) : int'(tgt);
    below = m < 16 * lo_rpm;
    above = m > 16 * hi_rpm;
    off   = below || above || (m == 0);
    if (below) begin
      r.duty = 8'(lo_duty);
    end else if (above) begin
      r.duty = 8'(hi_duty);
    end else begin
      p = duty_poly(m);
      if (p < lo_duty) r.duty = 8'(lo_duty);
      else if (p > hi_duty) r.duty = 8'(hi_duty);
      else r.duty = 8'(p);
    end
    r.drive_a      = !off && !neg;
    r.drive_b      = !off && neg;
    r.out_of_range = off;
    return r;
  endfunction

  function automatic string res_str(stmd_pkg::result_t r);
    return $sformatf("a=%0b b=%0b duty=%0d oor=%0b",
                     r.drive_a, r.drive_b, r.duty, r.out_of_range);
  endfunction

  function automatic int pick_gap(bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // mostly around and inside the speed window, some anywhere
  function automatic logic signed [15:0] pick_cmd();
    int r;
    int lo;
    int hi;
    int m;
    lo = 16 * lo_rpm;
    hi = 16 * hi_rpm;
    r  = $urandom_range(99);
    if (r < 15) return 16'($urandom);
    if (r < 35) m = ($urandom_range(1) ? lo : hi) + int'($urandom_range(4)) - 2;
    else if (lo <= hi) m = int'($urandom_range(hi, lo));
    else m = int'($urandom_range(32768));
    if (m < 0) m = 0;
    if (m > 32768) m = 32768;
    if (m == 32768 || (m != 0 && $urandom_range(1))) return 16'(-m);
    return 16'(m);
  endfunction

  // command of magnitude m in both directions where it exists
  task automatic push_mag(int m);
    if (m < 0 || m > 32768) return;
    if (m != 32768) cmd_q.push_back(16'(m));
    if (m != 0) cmd_q.push_back(16'(-m));
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || popped_cnt != checked_cnt) @(posedge clk);
  endtask

  task automatic set_reg(logic [stmd_pkg::CFG_IDX_W-1:0] idx,
                         logic [stmd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      stmd_pkg::REG_MIN_SPEED: lo_rpm = int'(val);
      stmd_pkg::REG_MAX_SPEED: hi_rpm = int'(val);
      stmd_pkg::REG_MIN_DUTY:  lo_duty = int'(val[7:0]);
      stmd_pkg::REG_MAX_DUTY:  hi_duty = int'(val[7:0]);
      default: ;
    endcase
  endtask

  // duty writes carry junk in the unused upper bits
  task automatic apply_setting(int ms, int xs, int nd, int xd);
    set_reg(stmd_pkg::REG_MIN_SPEED, 11'(ms));
    set_reg(stmd_pkg::REG_MAX_SPEED, 11'(xs));
    set_reg(stmd_pkg::REG_MIN_DUTY, {3'($urandom), 8'(nd)});
    set_reg(stmd_pkg::REG_MAX_DUTY, {3'($urandom), 8'(xd)});
  endtask

  initial begin
    int ph;
    int i;
    int ms;
    int xs;
    int nd;
    int xd;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    @(posedge rst_n);
    @(posedge clk);

    // reset settings: window edges, zero and full-scale commands
    push_mag(0);
    push_mag(1);
    push_mag(143);
    push_mag(144);
    push_mag(800);
    push_mag(1600);
    push_mag(2400);
    push_mag(2401);
    push_mag(32767);
    push_mag(32768);
    wait_drained();

    // writes to unmapped indexes must leave the registers alone
    set_reg(stmd_pkg::CFG_IDX_W'($urandom_range(127, 4)), 11'($urandom));
    set_reg(stmd_pkg::CFG_IDX_W'($urandom_range(255, 128)), 11'($urandom));

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 8) begin
        ms = SETTING_TBL[ph][0];
        xs = SETTING_TBL[ph][1];
        nd = SETTING_TBL[ph][2];
        xd = SETTING_TBL[ph][3];
      end else begin
        ms = $urandom_range(100);
        xs = ms + $urandom_range(300);
        nd = $urandom_range(255);
        xd = $urandom_range(255);
      end
      apply_setting(ms, xs, nd, xd);
      src_idle_en  <= (ph != 2) && ($urandom_range(3) != 0);
      snk_stall_en <= (ph != 2) && ($urandom_range(3) != 0);

      push_mag(0);
      push_mag(16 * lo_rpm - 1);
      push_mag(16 * lo_rpm);
      push_mag(8 * (lo_rpm + hi_rpm));
      push_mag(16 * hi_rpm);
      push_mag(16 * hi_rpm + 1);
      push_mag(32768);

      for (i = 0; i < RAND_PER_PH; i++) begin
        cmd_q.push_back(pick_cmd());
        // sender holds off until the pipe has emptied
        if (ph[0] && i == RAND_PER_PH / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("speed_to_motor_drive_map_core regression: pass");
    end else begin
      $display("speed_to_motor_drive_map_core regression: fail");
    end
    $finish;
  end

  // command driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.target_speed <= '0;
      src_gap            <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        drive_exp_q.push_back(drive_for_speed(in_ch.target_speed));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          in_ch.valid        <= 1'b0;
          in_ch.target_speed <= 16'($urandom);
          src_gap            <= src_gap - 1;
        end else if (cmd_q.size() != 0) begin
          in_ch.valid        <= 1'b1;
          in_ch.target_speed <= cmd_q.pop_front();
          popped_cnt++;
          src_gap            <= pick_gap(src_idle_en);
        end else begin
          in_ch.valid        <= 1'b0;
          in_ch.target_speed <= 16'($urandom);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_r.drive_a      = out_ch.drive_a;
        got_r.drive_b      = out_ch.drive_b;
        got_r.duty         = out_ch.duty;
        got_r.out_of_range = out_ch.out_of_range;
        if (drive_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transfer: expected none, actual %s", $time,
                   res_str(got_r));
        end else begin
          want_r = drive_exp_q.pop_front();
          checked_cnt++;
          if (got_r !== want_r) begin
            err_cnt++;
            $display("%0t: mismatch: expected %s, actual %s", $time,
                     res_str(want_r), res_str(got_r));
          end
        end
      end
      if (snk_stall != 0) begin
        out_ch.ready <= 1'b0;
        snk_stall    <= snk_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        snk_stall    <= pick_gap(snk_stall_en);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("speed_to_motor_drive_map_core regression: fail");
      $finish;
    end
  end

endmodule
